>>> rtl/core/dbq_pkg.sv
// Shared types and constants for the bounded deque with value purge.
`default_nettype none

package dbq_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned WordWidth    = 32;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_PURGE      = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_PURGE,
    S_DONE
  } state_e;

  typedef struct packed {
    status_e               status;
    logic [WordWidth-1:0]  popped_value;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/bounded_deque_with_value_purge_unit.sv
// Top level of the bounded deque with value purge: sequencer, store and result register.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o   | cmd_i, value_i
//   out     | output    | out_valid_o/out_stall_i | status_o, popped_value_o,
//           |           |                      | purged_count_o, occupancy_o
//
// A push, a refused push or pop and an unused code go from idle straight to the result state,
// a pop passes through a read state first, and a purge reads every stored entry in turn
// through the single read port of the entry store that the purge sweep walks.
// Reset clears the pointers and the occupancy; the store itself is not cleared.
// The result register lets the next word enter while a result waits on a stall.
`default_nettype none

module bounded_deque_with_value_purge_unit import dbq_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  cmd_i,
  input  logic signed [WordWidth-1:0] value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic signed [WordWidth-1:0] popped_value_o,
  output logic [CW-1:0]               purged_count_o,
  output logic [CW-1:0]               occupancy_o
);

  logic                 res_ready;
  logic                 res_valid;
  result_t              res;
  logic [CW-1:0]        res_purged;
  logic [CW-1:0]        res_occ;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WordWidth-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [WordWidth-1:0] mem_rdata;

  logic                 out_valid_q, out_valid_d;
  result_t              out_res_q;
  logic [CW-1:0]        out_purged_q;
  logic [CW-1:0]        out_occ_q;

  dbq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .res_ready_i  (res_ready),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_purged_o (res_purged),
    .res_occ_o    (res_occ),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  dbq_mem #(.DEPTH(DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_res_q    <= res;
      out_purged_q <= res_purged;
      out_occ_q    <= res_occ;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_res_q.status;
  assign popped_value_o = out_res_q.popped_value;
  assign purged_count_o = out_purged_q;
  assign occupancy_o    = out_occ_q;

endmodule

`default_nettype wire

>>> rtl/core/dbq_mem.sv
// Entry store: one write port and one registered read port.
`default_nettype none

module dbq_mem import dbq_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WordWidth-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WordWidth-1:0] rdata_o
);

  logic [WordWidth-1:0] mem_q [DEPTH];
  logic [WordWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/dbq_ctrl.sv
// Command sequencer: pointers, pops, and the read-compare-write purge sweep.
`default_nettype none

module dbq_ctrl import dbq_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           cmd_i,
  input  logic [WordWidth-1:0] value_i,
  input  logic                 res_ready_i,
  output logic                 res_valid_o,
  output result_t              res_o,
  output logic [CW-1:0]        res_purged_o,
  output logic [CW-1:0]        res_occ_o,
  output logic                 mem_we_o,
  output logic [AW-1:0]        mem_waddr_o,
  output logic [WordWidth-1:0] mem_wdata_o,
  output logic                 mem_re_o,
  output logic [AW-1:0]        mem_raddr_o,
  input  logic [WordWidth-1:0] mem_rdata_i
);

  state_e               state_q, state_d;
  logic [AW-1:0]        front_q, front_d;
  logic [CW-1:0]        count_q, count_d;
  logic [WordWidth-1:0] val_q, val_d;
  logic [CW-1:0]        rd_q, rd_d;
  logic [CW-1:0]        wr_q, wr_d;
  logic [CW-1:0]        purged_q, purged_d;
  logic                 pend_q, pend_d;
  status_e              status_q, status_d;
  logic [WordWidth-1:0] popped_q, popped_d;

  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] front, logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW + 1)'(front) + (CW + 1)'(off);
    if (sum >= (CW + 1)'(DEPTH)) begin
      sum = sum - (CW + 1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_inc(logic [AW-1:0] front);
    return (front == AW'(DEPTH - 1)) ? '0 : front + AW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_dec(logic [AW-1:0] front);
    return (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      count_q <= '0;
      rd_q    <= '0;
      wr_q    <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    purged_q <= purged_d;
    status_q <= status_d;
    popped_q <= popped_d;
  end

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    val_d       = val_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    purged_d    = purged_q;
    pend_d      = pend_q;
    status_d    = status_q;
    popped_d    = popped_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = val_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    res_valid_o = 1'b0;
    in_stall_o  = (state_q != S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d    = value_i;
          status_d = ST_OK;
          popped_d = '0;
          purged_d = '0;
          rd_d     = '0;
          wr_d     = '0;
          pend_d   = 1'b0;
          state_d  = S_DONE;
          case (cmd_e'(cmd_i))
            CMD_PUSH_FRONT: begin
              if (count_q == CW'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = slot_dec(front_q);
                mem_wdata_o = value_i;
                front_d     = slot_dec(front_q);
                count_d     = count_q + CW'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (count_q == CW'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = slot_of(front_q, count_q);
                mem_wdata_o = value_i;
                count_d     = count_q + CW'(1);
              end
            end
            CMD_POP_BACK: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = slot_of(front_q, count_q - CW'(1));
                count_d     = count_q - CW'(1);
                state_d     = S_POP;
              end
            end
            CMD_POP_FRONT: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = front_q;
                front_d     = slot_inc(front_q);
                count_d     = count_q - CW'(1);
                state_d     = S_POP;
              end
            end
            CMD_PURGE: begin
              state_d = S_PURGE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_POP: begin
        popped_d = mem_rdata_i;
        state_d  = S_DONE;
      end
      S_PURGE: begin
        if (pend_q) begin
          if (mem_rdata_i == val_q) begin
            purged_d = purged_q + CW'(1);
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = slot_of(front_q, wr_q);
            mem_wdata_o = mem_rdata_i;
            wr_d        = wr_q + CW'(1);
          end
        end
        if (rd_q != count_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = slot_of(front_q, rd_q);
          rd_d        = rd_q + CW'(1);
          pend_d      = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            count_d = wr_q;
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        res_valid_o = res_ready_i;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.status       = status_q;
  assign res_o.popped_value = popped_q;
  assign res_purged_o       = purged_q;
  assign res_occ_o          = count_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("occupancy exceeds the store depth");

  a_done_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> !mem_we_o)
    else $error("store written while a result is pending");

  a_purge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PURGE) |-> (wr_q <= rd_q) && (rd_q <= count_q))
    else $error("purge write pointer passed the read pointer");

  a_purge_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PURGE && state_d == S_DONE) |=>
      (count_q + purged_q == $past(count_q)))
    else $error("purge count and occupancy do not add up");
`endif

endmodule

`default_nettype wire
